### rtl/core/delta_list_timer_queue_top_defines.svh
// Assertion macros for the delta-list timer queue.
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DLTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLTQ_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLTQ_ASSERT(label, clk, rst_n, prop, msg)
`define DLTQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/core/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
package dltq_pkg;
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] delay;
        logic [7:0]  event_id;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [7:0] fired_id;
        logic       last;
    } t_out_item;
endpackage

### rtl/core/dltq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/dltq_front.sv
// Front end: a two-entry queue from the input to the engine.
module dltq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dltq_pkg::t_in_item i_in_item,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output dltq_pkg::t_in_item o_q_item
);
    import dltq_pkg::*;

    t_in_item   r_buf [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_item   = r_buf[r_rd];

    // store payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_in_item;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`include "delta_list_timer_queue_top_defines.svh"
    `DLTQ_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt != 2'd3), "front queue count overflow")
    `DLTQ_ASSERT(a_no_push_full, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !o_in_ready, "push when full")
    `DLTQ_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_cnt == 2'd1) |-> (r_rd != r_wr), "pointer mismatch")
endmodule

### rtl/core/dltq_engine.sv
// Back end: walks the delta list in RAM, inserts entries and pops on tick.
module dltq_engine #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DELAY_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  dltq_pkg::t_in_item  i_q_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dltq_pkg::t_out_item o_out_item
);
    import dltq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = DELAY_BITS + 1;
    localparam int EW = 8;
    // list entry: delta and event id
    localparam int RW = DW + EW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRD   = 4'd1;  // walk: read issued
    localparam logic [3:0] S_WCMP  = 4'd2;  // walk: compare
    localparam logic [3:0] S_SHRD  = 4'd3;  // shift up: read
    localparam logic [3:0] S_SHWR  = 4'd4;  // shift up: write
    localparam logic [3:0] S_INS   = 4'd5;  // write new entry
    localparam logic [3:0] S_FIX   = 4'd6;  // reduce follower delta
    localparam logic [3:0] S_OUT   = 4'd7;  // wait output slot
    localparam logic [3:0] S_TRD   = 4'd8;  // tick: head read
    localparam logic [3:0] S_TCHK  = 4'd9;  // tick: head check
    localparam logic [3:0] S_PRD   = 4'd10; // pop: read next
    localparam logic [3:0] S_PWR   = 4'd11; // pop: shift down
    localparam logic [3:0] S_NRD   = 4'd12; // check new head
    localparam logic [3:0] S_NCHK  = 4'd13;
    localparam logic [3:0] S_FWAIT = 4'd14; // emit fired item

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_idx, n_idx;
    logic [DW-1:0] r_rem, n_rem;
    logic [EW-1:0] r_id, n_id;
    logic [EW-1:0] r_fid, n_fid;
    logic          r_ov, n_ov;
    t_out_item     r_out, n_out;
    logic          r_fire_last, n_fire_last;
    logic [CW-1:0] r_nfired, n_nfired;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_wdata, w_rdata;
    logic [DW-1:0] w_rdelta;
    logic [EW-1:0] w_revent;

    dltq_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rdelta   = w_rdata[RW-1:EW];
    assign w_revent   = w_rdata[EW-1:0];
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign o_q_ready   = (r_state == S_IDLE) && !r_ov;

    // sequence insert and tick work
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_id    = r_id;
        n_fid   = r_fid;
        n_ov    = r_ov;
        n_out   = r_out;
        n_fire_last = r_fire_last;
        n_nfired = r_nfired;
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = {r_rem, r_id};
        w_raddr = r_idx[AW-1:0];
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && o_q_ready) begin
                    if (i_q_item.func == FUNC_INSERT) begin
                        n_rem = {1'b0, DELAY_BITS'(i_q_item.delay)};
                        n_id  = i_q_item.event_id;
                        n_pos = '0;
                        n_idx = '0;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_out = '{kind: KIND_ACK, status: STATUS_FULL,
                                      fired_id: '0, last: 1'b1};
                            n_ov  = 1'b1;
                        end else if (r_count == '0) begin
                            n_state = S_INS;
                        end else begin
                            n_state = S_WRD;
                        end
                    end else if (r_count != '0) begin
                        n_idx    = '0;
                        n_nfired = '0;
                        n_state  = S_TRD;
                    end
                end
            end
            S_WRD: begin
                w_raddr = r_pos[AW-1:0];
                n_state = S_WCMP;
            end
            S_WCMP: begin
                if (r_rem >= w_rdelta) begin
                    n_rem = r_rem - w_rdelta;
                    n_pos = r_pos + 1'b1;
                    n_state = ((r_pos + 1'b1) == r_count) ? S_INS : S_WRD;
                end else begin
                    n_idx   = r_count;
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                // read entry idx-1, to move into idx
                w_raddr = AW'(r_idx - 1'b1);
                n_state = S_SHWR;
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
                n_idx   = r_idx - 1'b1;
                n_state = ((r_idx - 1'b1) == r_pos) ? S_INS : S_SHRD;
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = {r_rem, r_id};
                n_count = r_count + 1'b1;
                w_raddr = AW'(r_pos + 1'b1);
                n_state = ((r_pos + 1'b1) < (r_count + 1'b1)) ? S_FIX : S_OUT;
            end
            S_FIX: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_pos + 1'b1);
                w_wdata = {w_rdelta - r_rem, w_revent};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_out = '{kind: KIND_ACK, status: STATUS_OK,
                              fired_id: '0, last: 1'b1};
                    n_ov  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TRD: begin
                w_raddr = '0;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (w_rdelta > DW'(1)) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = {w_rdelta - 1'b1, w_revent};
                    n_state = S_IDLE;
                end else begin
                    n_fid   = w_revent;
                    n_idx   = CW'(1);
                    n_state = (r_count > CW'(1)) ? S_PRD : S_NCHK;
                end
            end
            S_PRD: begin
                w_raddr = r_idx[AW-1:0];
                n_state = S_PWR;
            end
            S_PWR: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_idx - 1'b1);
                w_wdata = w_rdata;
                n_idx   = r_idx + 1'b1;
                n_state = ((r_idx + 1'b1) < r_count) ? S_PRD : S_NCHK;
            end
            S_NCHK: begin
                // pop done: count shrinks, see if next head fires too
                n_count  = r_count - 1'b1;
                n_nfired = r_nfired + 1'b1;
                w_raddr  = '0;
                n_state  = S_NRD;
            end
            S_NRD: begin
                // keep the new head on the read port
                w_raddr = '0;
                n_fire_last = !((r_count != '0) && (w_rdelta == '0)
                                && (r_nfired < CW'(QUEUE_DEPTH)));
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                w_raddr = '0;
                if (!r_ov || i_out_ready) begin
                    n_out = '{kind: KIND_FIRED, status: STATUS_OK,
                              fired_id: r_fid, last: r_fire_last};
                    n_ov  = 1'b1;
                    if (r_fire_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fid   = w_revent;
                        n_idx   = CW'(1);
                        n_state = (r_count > CW'(1)) ? S_PRD : S_NCHK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_id        <= n_id;
        r_fid       <= n_fid;
        r_out       <= n_out;
        r_fire_last <= n_fire_last;
        r_nfired    <= n_nfired;
    end

`include "delta_list_timer_queue_top_defines.svh"
    `DLTQ_ASSERT(a_count_max, i_clk, i_rst_n, (r_count <= CW'(QUEUE_DEPTH)), "count overflow")
    `DLTQ_ASSERT(a_out_hold, i_clk, i_rst_n, (r_ov && !i_out_ready) |=> (r_ov && $stable(r_out)), "output dropped")
    `DLTQ_ASSERT(a_ready_idle, i_clk, i_rst_n, o_q_ready |-> (r_state == S_IDLE), "ready outside idle")
endmodule

### rtl/core/delta_list_timer_queue_top.sv
// Delta-list timer queue: insert walks the list in RAM, tick pops fired events.
// Insert: compares entries along the list, shifts later entries up, then writes the new entry,
// reduces the delta of the following entry if there is one, and acks.
// Tick: decrements the head delta when nothing fires; each fired event pops the head entry.
// The engine holds one item at a time and takes the next once the last result has left.
module delta_list_timer_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DELAY_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dltq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dltq_pkg::t_out_item o_out_item
);
    import dltq_pkg::*;

    logic     w_q_valid;
    logic     w_q_ready;
    t_in_item w_q_item;

    dltq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    dltq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .DELAY_BITS(DELAY_BITS)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_item   (w_q_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );
endmodule

### verif/tb.sv
// Testbench for the delta-list timer queue: directed table, then random items.
`timescale 1ns / 100ps

module tb;
    import dltq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int N_RANDOM     = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    delta_list_timer_queue_top #(.QUEUE_DEPTH(DEPTH), .DELAY_BITS(16)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Directed row: item plus an optional typed-in expectation.
    typedef struct {
        t_in_item  item;
        logic      has_exp;
        t_out_item exp;
    } t_row;

    // Predicted timer list
    logic [16:0] list_delta [DEPTH];
    logic [7:0]  list_event [DEPTH];
    int          list_len;

    t_out_item pending_q [$];

    int  n_mismatch;
    int  cycle_cnt;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Remove the head entry of the predicted list.
    function automatic void pop_timer_head();
        for (int i = 1; i < list_len; i++) begin
            list_delta[i-1] = list_delta[i];
            list_event[i-1] = list_event[i];
        end
        list_len--;
    endfunction

    // Advance the predicted list by one item and queue the results it causes.
    function automatic void predict_timer(t_in_item it);
        logic [16:0] rem;
        int          pos;
        t_out_item   r;
        int          n;
        rem = {1'b0, it.delay};
        pos = 0;
        n = 0;
        if (it.func == FUNC_INSERT) begin
            r = '{kind: KIND_ACK, status: STATUS_OK, fired_id: 8'd0, last: 1'b1};
            if (list_len >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                while (pos < list_len && rem >= list_delta[pos]) begin
                    rem -= list_delta[pos];
                    pos++;
                end
                for (int i = list_len; i > pos; i--) begin
                    list_delta[i] = list_delta[i-1];
                    list_event[i] = list_event[i-1];
                end
                list_delta[pos] = rem;
                list_event[pos] = it.event_id;
                list_len++;
                if (pos + 1 < list_len) list_delta[pos+1] -= rem;
            end
            pending_q.push_back(r);
        end else if (list_len > 0) begin
            if (list_delta[0] > 1) begin
                list_delta[0] -= 1;
            end else begin
                r = '{kind: KIND_FIRED, status: STATUS_OK, fired_id: list_event[0], last: 1'b0};
                pending_q.push_back(r);
                pop_timer_head();
                n = 1;
                while (list_len > 0 && list_delta[0] == 0 && n < DEPTH) begin
                    r.fired_id = list_event[0];
                    pending_q.push_back(r);
                    pop_timer_head();
                    n++;
                end
                pending_q[$].last = 1'b1;
            end
        end
    endfunction

    // Compare one output item against the oldest expectation.
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected item %p", got);
        end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        end
    endtask

    // Send one item, honoring the sender's idle ratio; valid stays up after accept.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_timer(it);
    endtask

    function automatic t_in_item make_insert(int dly, int id);
        return '{func: FUNC_INSERT, delay: dly[15:0], event_id: id[7:0]};
    endfunction

    function automatic t_in_item make_tick();
        return '{func: FUNC_TICK, delay: 16'($urandom), event_id: 8'($urandom)};
    endfunction

    // Drop valid and wait until every expected result has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Collect output items
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_item);
    end

    // Drive receiver ready, with random idling and long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count the long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            recv_hold   <= 1'b1;
        end else begin
            recv_hold <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main stimulus
    initial begin
        t_row rows [$];
        t_in_item it;
        int kind_sel;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        n_mismatch    = 0;
        cycle_cnt     = 0;
        list_len      = 0;
        recv_hold     = 1'b0;
        hold_cycles   = 0;
        send_idle_pct = 28;
        recv_idle_pct = 85;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty tick, extremes, ties, zero delay, full queue
        rows.push_back('{make_tick(), 1'b0, '0});
        rows.push_back('{make_insert(0, 8'hFF), 1'b1,
                         '{KIND_ACK, STATUS_OK, 8'd0, 1'b1}});
        rows.push_back('{make_tick(), 1'b1, '{KIND_FIRED, STATUS_OK, 8'hFF, 1'b1}});
        rows.push_back('{make_insert(65535, 8'h00), 1'b0, '0});
        rows.push_back('{make_insert(2, 8'h11), 1'b0, '0});
        rows.push_back('{make_insert(2, 8'h12), 1'b0, '0});
        rows.push_back('{make_insert(3, 8'h13), 1'b0, '0});
        rows.push_back('{make_tick(), 1'b0, '0});
        rows.push_back('{make_tick(), 1'b0, '0});
        rows.push_back('{make_tick(), 1'b0, '0});
        for (int i = 0; i < 15; i++) rows.push_back('{make_insert(5, i), 1'b0, '0});
        rows.push_back('{make_insert(7, 8'hAA), 1'b1,
                         '{KIND_ACK, STATUS_FULL, 8'd0, 1'b1}});
        foreach (rows[k]) begin
            if (rows[k].has_exp) begin
                wait_drained();
                send_item(rows[k].item);
                pending_q[$] = rows[k].exp;
            end else begin
                send_item(rows[k].item);
            end
        end
        // Fire the short-delay entries, all on one tick
        repeat (6) send_item(make_tick());
        wait_drained();

        // Random part in three idling phases
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 28;
                hold_cycles <= 300;
            end
            if (n == 2 * N_RANDOM / 3) begin
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind_sel = $urandom_range(99);
            if (kind_sel < 55) begin
                it = make_insert(($urandom_range(3) == 0) ? $urandom : $urandom_range(12),
                                 $urandom);
            end else begin
                it = make_tick();
            end
            send_item(it);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
